### sv/dsmpi_pkg.sv
// Types and codes shared by the dual-SIM modem power interlock.
package dsmpi_pkg;

  typedef enum logic [3:0] {
    CMD_RECOVERY_FALLBACK = 4'd0,
    CMD_VERIFY_OFF        = 4'd1,
    CMD_MUX_OFF           = 4'd2,
    CMD_VERIFY_MUX_OFF    = 4'd3,
    CMD_RAIL_OFF          = 4'd4,
    CMD_SELECT            = 4'd5,
    CMD_RAIL_ON           = 4'd6,
    CMD_POWER_GOOD        = 4'd7,
    CMD_MUX_ON            = 4'd8,
    CMD_VERIFY_MUX_ON     = 4'd9,
    CMD_PWRKEY            = 4'd10
  } cmd_e;

  typedef enum logic [2:0] {
    ST_FAILED  = 3'd0,
    ST_OK      = 3'd1,
    ST_WAITING = 3'd2,
    ST_PHYS    = 3'd3,
    ST_LOGIC   = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    PIN_PWRKEY  = 2'd0,
    PIN_MUX_EN  = 2'd1,
    PIN_RAIL    = 2'd2,
    PIN_MUX_SEL = 2'd3
  } pin_e;

  typedef enum logic {
    REG_PULSE_LENGTH = 1'b0,
    REG_STABLE_TIME  = 1'b1
  } cfg_reg_e;

  localparam int unsigned CfgDataW = 16;
  localparam logic [15:0] PulseLengthReset = 16'd1500;
  localparam logic [15:0] StableTimeReset  = 16'd100;

  localparam logic [1:0] SlotNone = 2'd0;
  localparam logic [1:0] Slot1    = 2'd1;
  localparam logic [1:0] Slot2    = 2'd2;

  typedef struct packed {
    logic [3:0]  command;
    logic [31:0] time_ms;
    logic [1:0]  slot_request;
    logic        arg_flag;
    logic        cell_status_level;
    logic        rail_enable_level;
    logic        mux_enable_level;
    logic        mux_select_level;
    logic        power_good_level;
    logic        switch_enable_n_level;
    logic        switch_sense_present;
    logic        write_ok;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic       drive_valid;
    logic [1:0] drive_pin;
    logic       drive_level;
    logic [1:0] slot_now;
    logic       power_stable_now;
  } out_item_t;

  typedef struct packed {
    logic [15:0] pulse_length_ms;
    logic [15:0] stable_time_ms;
  } cfg_t;

  typedef struct packed {
    logic        pulse_active;
    logic [31:0] pulse_start_time;
    logic        modem_off_seen;
    logic        mux_off_verified;
    logic        pg_tracking;
    logic [31:0] pg_high_since;
    logic        pg_stable;
    logic        slot_known;
    logic [1:0]  current_slot;
  } state_t;

endpackage

### sv/dual_sim_modem_power_interlock.sv
// Top level: input register, flag state, config registers and result register.
//
//   channel  | valid       | stall        | payload
//   ---------+-------------+--------------+---------------------------
//   command  | in_valid_i  | in_stall_o   | in_data_i  (in_item_t)
//   result   | out_valid_o | out_stall_i  | out_data_o (out_item_t)
//   config   | cfg_we_i    | (none)       | cfg_index_i, cfg_wdata_i
//
// One transaction per cycle while the result is not stalled: a command is
// held in the input register, then the interlock logic updates the flags
// and loads the result register, which then holds the valid result.
// A stalled result holds the pipe; the input register still takes one more
// transaction. Reset clears all flags and reloads the config defaults.
module dual_sim_modem_power_interlock (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  dsmpi_pkg::in_item_t           in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output dsmpi_pkg::out_item_t          out_data_o,
  input  logic                          cfg_we_i,
  input  logic                          cfg_index_i,
  input  logic [dsmpi_pkg::CfgDataW-1:0] cfg_wdata_i
);

  logic                 in_valid_q;
  dsmpi_pkg::in_item_t  in_data_q;
  logic                 out_valid_q;
  dsmpi_pkg::out_item_t out_data_q;
  dsmpi_pkg::state_t    state_q;
  dsmpi_pkg::state_t    state_d;
  dsmpi_pkg::cfg_t      cfg_q;
  dsmpi_pkg::out_item_t result_d;
  logic                 advance;
  logic                 in_ready;

  assign advance     = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_ready    = !in_valid_q || advance;
  assign in_stall_o  = !in_ready;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  dsmpi_logic u_logic (
    .item_i   (in_data_q),
    .state_i  (state_q),
    .cfg_i    (cfg_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
      cfg_q.pulse_length_ms <= dsmpi_pkg::PulseLengthReset;
      cfg_q.stable_time_ms  <= dsmpi_pkg::StableTimeReset;
    end else begin
      if (in_ready) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (dsmpi_pkg::cfg_reg_e'(cfg_index_i))
          dsmpi_pkg::REG_PULSE_LENGTH: cfg_q.pulse_length_ms <= cfg_wdata_i;
          dsmpi_pkg::REG_STABLE_TIME:  cfg_q.stable_time_ms  <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_valid_i) begin
      in_data_q <= in_data_i;
    end
    if (advance) begin
      out_data_q <= result_d;
    end
  end

endmodule

### sv/dsmpi_logic.sv
// Interlock checks, flag next state and result for one command.
module dsmpi_logic (
  input  dsmpi_pkg::in_item_t  item_i,
  input  dsmpi_pkg::state_t    state_i,
  input  dsmpi_pkg::cfg_t      cfg_i,
  output dsmpi_pkg::state_t    state_o,
  output dsmpi_pkg::out_item_t result_o
);

  logic [31:0] pulse_elapsed;
  logic [31:0] pg_elapsed;
  logic        pulse_done;
  logic        pg_done;

  assign pulse_elapsed = item_i.time_ms - state_i.pulse_start_time;
  assign pg_elapsed    = item_i.time_ms - state_i.pg_high_since;
  assign pulse_done    = pulse_elapsed >= {16'd0, cfg_i.pulse_length_ms};
  assign pg_done       = pg_elapsed >= {16'd0, cfg_i.stable_time_ms};

  always_comb begin
    dsmpi_pkg::state_t    s;
    dsmpi_pkg::out_item_t r;
    logic                 wok;
    logic                 modem_on;
    logic                 rail;
    logic                 mux_en;
    logic                 pg;
    logic                 sense;
    logic                 sw_n;
    logic                 sel_lvl;
    s       = state_i;
    r       = '0;
    r.status = dsmpi_pkg::ST_FAILED;
    wok      = item_i.write_ok;
    modem_on = item_i.cell_status_level;
    rail    = item_i.rail_enable_level;
    mux_en  = item_i.mux_enable_level;
    pg      = item_i.power_good_level;
    sense   = item_i.switch_sense_present;
    sw_n    = item_i.switch_enable_n_level;
    sel_lvl = (state_i.current_slot == dsmpi_pkg::Slot2);

    case (dsmpi_pkg::cmd_e'(item_i.command))
      dsmpi_pkg::CMD_RECOVERY_FALLBACK: begin
        if (!modem_on) begin
          if (!(state_i.pulse_active && !wok)) begin
            if (state_i.pulse_active) begin
              r.drive_valid = 1'b1;
              r.drive_pin   = dsmpi_pkg::PIN_PWRKEY;
              r.drive_level = 1'b0;
            end
            s.pulse_active   = 1'b0;
            s.modem_off_seen = 1'b1;
            r.status         = dsmpi_pkg::ST_PHYS;
          end
        end else if (!item_i.arg_flag) begin
          r.status = dsmpi_pkg::ST_WAITING;
        end else if (!state_i.pulse_active) begin
          if (wok) begin
            r.drive_valid      = 1'b1;
            r.drive_pin        = dsmpi_pkg::PIN_PWRKEY;
            r.drive_level      = 1'b1;
            s.pulse_active     = 1'b1;
            s.pulse_start_time = item_i.time_ms;
            r.status           = dsmpi_pkg::ST_WAITING;
          end
        end else if (!pulse_done) begin
          r.status = dsmpi_pkg::ST_WAITING;
        end else if (wok) begin
          r.drive_valid  = 1'b1;
          r.drive_pin    = dsmpi_pkg::PIN_PWRKEY;
          r.drive_level  = 1'b0;
          s.pulse_active = 1'b0;
          r.status       = dsmpi_pkg::ST_PHYS;
        end
      end
      dsmpi_pkg::CMD_VERIFY_OFF: begin
        if (!modem_on) begin
          s.modem_off_seen = 1'b1;
          r.status         = dsmpi_pkg::ST_OK;
        end
      end
      dsmpi_pkg::CMD_MUX_OFF: begin
        if (state_i.modem_off_seen && !modem_on && wok) begin
          r.drive_valid      = 1'b1;
          r.drive_pin        = dsmpi_pkg::PIN_MUX_EN;
          r.drive_level      = 1'b0;
          s.mux_off_verified = 1'b0;
          s.pg_stable        = 1'b0;
          r.status           = dsmpi_pkg::ST_OK;
        end
      end
      dsmpi_pkg::CMD_VERIFY_MUX_OFF: begin
        if (!mux_en) begin
          if (!sense) begin
            s.mux_off_verified = 1'b1;
            r.status           = dsmpi_pkg::ST_LOGIC;
          end else if (sw_n) begin
            s.mux_off_verified = 1'b1;
            r.status           = dsmpi_pkg::ST_PHYS;
          end
        end
      end
      dsmpi_pkg::CMD_RAIL_OFF: begin
        if (state_i.modem_off_seen && state_i.mux_off_verified && !modem_on && !mux_en &&
            !(sense && !sw_n) && wok) begin
          r.drive_valid  = 1'b1;
          r.drive_pin    = dsmpi_pkg::PIN_RAIL;
          r.drive_level  = 1'b0;
          s.slot_known   = 1'b0;
          s.current_slot = dsmpi_pkg::SlotNone;
          s.pg_tracking  = 1'b0;
          s.pg_stable    = 1'b0;
          r.status       = dsmpi_pkg::ST_OK;
        end
      end
      dsmpi_pkg::CMD_SELECT: begin
        if ((item_i.slot_request == dsmpi_pkg::Slot1 ||
             item_i.slot_request == dsmpi_pkg::Slot2) &&
            !rail && !modem_on && !mux_en && wok) begin
          r.drive_valid  = 1'b1;
          r.drive_pin    = dsmpi_pkg::PIN_MUX_SEL;
          r.drive_level  = (item_i.slot_request == dsmpi_pkg::Slot2);
          s.slot_known   = 1'b1;
          s.current_slot = item_i.slot_request;
          r.status       = dsmpi_pkg::ST_OK;
        end
      end
      dsmpi_pkg::CMD_RAIL_ON: begin
        if (state_i.slot_known && !rail && !modem_on &&
            (item_i.mux_select_level == sel_lvl) && !mux_en && wok) begin
          r.drive_valid    = 1'b1;
          r.drive_pin      = dsmpi_pkg::PIN_RAIL;
          r.drive_level    = 1'b1;
          s.modem_off_seen = 1'b0;
          s.pg_tracking    = 1'b0;
          s.pg_stable      = 1'b0;
          r.status         = dsmpi_pkg::ST_OK;
        end
      end
      dsmpi_pkg::CMD_POWER_GOOD: begin
        if (rail) begin
          if (!pg) begin
            s.pg_tracking = 1'b0;
            s.pg_stable   = 1'b0;
            r.status      = dsmpi_pkg::ST_WAITING;
          end else if (!state_i.pg_tracking) begin
            s.pg_tracking   = 1'b1;
            s.pg_high_since = item_i.time_ms;
            r.status        = dsmpi_pkg::ST_WAITING;
          end else if (!pg_done) begin
            r.status = dsmpi_pkg::ST_WAITING;
          end else begin
            s.pg_stable = 1'b1;
            r.status    = dsmpi_pkg::ST_PHYS;
          end
        end
      end
      dsmpi_pkg::CMD_MUX_ON: begin
        if (state_i.pg_stable && rail && pg && wok) begin
          r.drive_valid      = 1'b1;
          r.drive_pin        = dsmpi_pkg::PIN_MUX_EN;
          r.drive_level      = 1'b1;
          s.mux_off_verified = 1'b0;
          r.status           = dsmpi_pkg::ST_OK;
        end
      end
      dsmpi_pkg::CMD_VERIFY_MUX_ON: begin
        if (state_i.pg_stable && rail && pg && mux_en) begin
          if (!sense) begin
            r.status = dsmpi_pkg::ST_LOGIC;
          end else if (!sw_n) begin
            r.status = dsmpi_pkg::ST_PHYS;
          end
        end
      end
      dsmpi_pkg::CMD_PWRKEY: begin
        if ((!item_i.arg_flag ||
             (state_i.pg_stable && rail && pg && mux_en && !(sense && sw_n))) && wok) begin
          r.drive_valid = 1'b1;
          r.drive_pin   = dsmpi_pkg::PIN_PWRKEY;
          r.drive_level = item_i.arg_flag;
          r.status      = dsmpi_pkg::ST_OK;
        end
      end
      default: begin
      end
    endcase

    r.slot_now         = s.current_slot;
    r.power_stable_now = s.pg_stable;
    state_o  = s;
    result_o = r;
  end

endmodule

### sim/testbench.sv
// Self-checking testbench for the dual-SIM modem power interlock sequencer.
module testbench;

  localparam logic [3:0] CmdUnknownLo = 4'd11;
  localparam logic [3:0] CmdUnknownHi = 4'd15;
  localparam logic [1:0] SlotBad      = 2'd3;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  dsmpi_pkg::in_item_t  in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  dsmpi_pkg::out_item_t out_data;
  logic                 cfg_we = 1'b0;
  dsmpi_pkg::cfg_reg_e  cfg_index = dsmpi_pkg::REG_PULSE_LENGTH;
  logic [15:0]          cfg_wdata = '0;

  dsmpi_pkg::in_item_t  pending_cmds[$];
  dsmpi_pkg::out_item_t expected_results[$];
  dsmpi_pkg::state_t    modem_flags = '0;
  dsmpi_pkg::cfg_t      timing_cfg;
  logic [31:0]          gen_time = '0;
  int unsigned          queued_n = 0;
  int unsigned          results_seen = 0;
  int unsigned          errors = 0;
  int unsigned          burst_left = 0;
  int unsigned          gap_left = 0;
  int unsigned          stall_run = 0;
  int unsigned          stall_mode = 0;
  dsmpi_pkg::out_item_t want_item;

  dual_sim_modem_power_interlock i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata)
  );

  always #10 clk_i = ~clk_i;

  function automatic dsmpi_pkg::out_item_t drove(input dsmpi_pkg::out_item_t r,
                                                 input dsmpi_pkg::pin_e pin,
                                                 input logic lvl);
    r.drive_valid = 1'b1;
    r.drive_pin   = pin;
    r.drive_level = lvl;
    return r;
  endfunction

  function automatic dsmpi_pkg::status_e switch_check(input logic present,
                                                      input logic level_n,
                                                      input logic want_n);
    if (!present) return dsmpi_pkg::ST_LOGIC;
    return (level_n == want_n) ? dsmpi_pkg::ST_PHYS : dsmpi_pkg::ST_FAILED;
  endfunction

  function automatic dsmpi_pkg::out_item_t predict_interlock(input dsmpi_pkg::in_item_t c);
    dsmpi_pkg::out_item_t r;
    dsmpi_pkg::state_t    nxt;
    logic [31:0]          elapsed;
    logic                 wr;
    r = '0;
    r.status = dsmpi_pkg::ST_FAILED;
    nxt = modem_flags;
    wr = c.write_ok;
    case (c.command)
      dsmpi_pkg::CMD_RECOVERY_FALLBACK: begin
        if (!c.cell_status_level) begin
          if (!nxt.pulse_active || wr) begin
            if (nxt.pulse_active) r = drove(r, dsmpi_pkg::PIN_PWRKEY, 1'b0);
            nxt.pulse_active   = 1'b0;
            nxt.modem_off_seen = 1'b1;
            r.status = dsmpi_pkg::ST_PHYS;
          end
        end else if (!c.arg_flag) begin
          r.status = dsmpi_pkg::ST_WAITING;
        end else if (!nxt.pulse_active) begin
          if (wr) begin
            r = drove(r, dsmpi_pkg::PIN_PWRKEY, 1'b1);
            nxt.pulse_active     = 1'b1;
            nxt.pulse_start_time = c.time_ms;
            r.status = dsmpi_pkg::ST_WAITING;
          end
        end else begin
          elapsed = c.time_ms - nxt.pulse_start_time;
          if (elapsed < {16'd0, timing_cfg.pulse_length_ms}) begin
            r.status = dsmpi_pkg::ST_WAITING;
          end else if (wr) begin
            r = drove(r, dsmpi_pkg::PIN_PWRKEY, 1'b0);
            nxt.pulse_active = 1'b0;
            r.status = dsmpi_pkg::ST_PHYS;
          end
        end
      end
      dsmpi_pkg::CMD_VERIFY_OFF: begin
        if (!c.cell_status_level) begin
          nxt.modem_off_seen = 1'b1;
          r.status = dsmpi_pkg::ST_OK;
        end
      end
      dsmpi_pkg::CMD_MUX_OFF: begin
        if (nxt.modem_off_seen && !c.cell_status_level && wr) begin
          r = drove(r, dsmpi_pkg::PIN_MUX_EN, 1'b0);
          nxt.mux_off_verified = 1'b0;
          nxt.pg_stable = 1'b0;
          r.status = dsmpi_pkg::ST_OK;
        end
      end
      dsmpi_pkg::CMD_VERIFY_MUX_OFF: begin
        if (!c.mux_enable_level) begin
          r.status = switch_check(c.switch_sense_present, c.switch_enable_n_level, 1'b1);
          if (r.status != dsmpi_pkg::ST_FAILED) nxt.mux_off_verified = 1'b1;
        end
      end
      dsmpi_pkg::CMD_RAIL_OFF: begin
        if (nxt.modem_off_seen && nxt.mux_off_verified && !c.cell_status_level &&
            !c.mux_enable_level && !(c.switch_sense_present && !c.switch_enable_n_level) &&
            wr) begin
          r = drove(r, dsmpi_pkg::PIN_RAIL, 1'b0);
          nxt.slot_known   = 1'b0;
          nxt.current_slot = dsmpi_pkg::SlotNone;
          nxt.pg_tracking  = 1'b0;
          nxt.pg_stable    = 1'b0;
          r.status = dsmpi_pkg::ST_OK;
        end
      end
      dsmpi_pkg::CMD_SELECT: begin
        if ((c.slot_request == dsmpi_pkg::Slot1 || c.slot_request == dsmpi_pkg::Slot2) &&
            !c.rail_enable_level && !c.cell_status_level && !c.mux_enable_level && wr) begin
          r = drove(r, dsmpi_pkg::PIN_MUX_SEL, c.slot_request == dsmpi_pkg::Slot2);
          nxt.slot_known   = 1'b1;
          nxt.current_slot = c.slot_request;
          r.status = dsmpi_pkg::ST_OK;
        end
      end
      dsmpi_pkg::CMD_RAIL_ON: begin
        if (nxt.slot_known && !c.rail_enable_level && !c.cell_status_level &&
            c.mux_select_level == (nxt.current_slot == dsmpi_pkg::Slot2) &&
            !c.mux_enable_level && wr) begin
          r = drove(r, dsmpi_pkg::PIN_RAIL, 1'b1);
          nxt.modem_off_seen = 1'b0;
          nxt.pg_tracking    = 1'b0;
          nxt.pg_stable      = 1'b0;
          r.status = dsmpi_pkg::ST_OK;
        end
      end
      dsmpi_pkg::CMD_POWER_GOOD: begin
        if (c.rail_enable_level) begin
          elapsed = c.time_ms - nxt.pg_high_since;
          if (!c.power_good_level) begin
            nxt.pg_tracking = 1'b0;
            nxt.pg_stable   = 1'b0;
            r.status = dsmpi_pkg::ST_WAITING;
          end else if (!nxt.pg_tracking) begin
            nxt.pg_tracking   = 1'b1;
            nxt.pg_high_since = c.time_ms;
            r.status = dsmpi_pkg::ST_WAITING;
          end else if (elapsed < {16'd0, timing_cfg.stable_time_ms}) begin
            r.status = dsmpi_pkg::ST_WAITING;
          end else begin
            nxt.pg_stable = 1'b1;
            r.status = dsmpi_pkg::ST_PHYS;
          end
        end
      end
      dsmpi_pkg::CMD_MUX_ON: begin
        if (nxt.pg_stable && c.rail_enable_level && c.power_good_level && wr) begin
          r = drove(r, dsmpi_pkg::PIN_MUX_EN, 1'b1);
          nxt.mux_off_verified = 1'b0;
          r.status = dsmpi_pkg::ST_OK;
        end
      end
      dsmpi_pkg::CMD_VERIFY_MUX_ON: begin
        if (nxt.pg_stable && c.rail_enable_level && c.power_good_level && c.mux_enable_level)
          r.status = switch_check(c.switch_sense_present, c.switch_enable_n_level, 1'b0);
      end
      dsmpi_pkg::CMD_PWRKEY: begin
        if ((!c.arg_flag || (nxt.pg_stable && c.rail_enable_level && c.power_good_level &&
             c.mux_enable_level && !(c.switch_sense_present && c.switch_enable_n_level))) &&
            wr) begin
          r = drove(r, dsmpi_pkg::PIN_PWRKEY, c.arg_flag);
          r.status = dsmpi_pkg::ST_OK;
        end
      end
      default: ;
    endcase
    r.slot_now = nxt.current_slot;
    r.power_stable_now = nxt.pg_stable;
    modem_flags = nxt;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= 100) $display("MISMATCH at result %0d: %s", results_seen, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  // Command driver: bursts of transactions with random gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_data <= '0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) expected_results.push_back(predict_interlock(pending_cmds.pop_front()));
      if (!in_valid || !in_stall) begin
        if (gap_left > 0 || pending_cmds.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_data <= pending_cmds[0];
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
    end
  end

  // Result monitor with its own stall pattern.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
      stall_run = 0;
      stall_mode = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with no pending expectation");
        end else begin
          want_item = expected_results.pop_front();
          check_field("status", 32'(out_data.status), 32'(want_item.status));
          check_field("drive_valid", 32'(out_data.drive_valid), 32'(want_item.drive_valid));
          check_field("drive_pin", 32'(out_data.drive_pin), 32'(want_item.drive_pin));
          check_field("drive_level", 32'(out_data.drive_level), 32'(want_item.drive_level));
          check_field("slot_now", 32'(out_data.slot_now), 32'(want_item.slot_now));
          check_field("power_stable_now", 32'(out_data.power_stable_now),
                      32'(want_item.power_stable_now));
        end
        results_seen++;
      end
      if (stall_run == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_run = $urandom_range(10, 80);
      end else begin
        stall_run--;
      end
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        2:       out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= ~out_stall;
      endcase
    end
  end

  task automatic push_item(input dsmpi_pkg::in_item_t it);
    pending_cmds.push_back(it);
    queued_n++;
  endtask

  function automatic dsmpi_pkg::in_item_t base_item(input logic [3:0] cmd);
    dsmpi_pkg::in_item_t it;
    it = '0;
    it.command = cmd;
    it.time_ms = gen_time;
    it.write_ok = 1'b1;
    return it;
  endfunction

  function automatic dsmpi_pkg::in_item_t random_item(input logic [3:0] cmd);
    dsmpi_pkg::in_item_t it;
    logic [63:0]         raw;
    raw = {$urandom, $urandom};
    it = raw[$bits(dsmpi_pkg::in_item_t)-1:0];
    it.command = cmd;
    it.time_ms = gen_time;
    return it;
  endfunction

  function automatic dsmpi_pkg::in_item_t seq_item(input logic [3:0] cmd);
    dsmpi_pkg::in_item_t it;
    gen_time += $urandom_range(0, 2);
    it = random_item(cmd);
    if ($urandom_range(0, 19) != 0) it.write_ok = 1'b1;
    return it;
  endfunction

  function automatic bit tidy();
    return $urandom_range(0, 11) != 0;
  endfunction

  task automatic advance_time(input int unsigned span);
    gen_time += $urandom_range(0, span);
  endtask

  task automatic queue_power_cycle();
    dsmpi_pkg::in_item_t it;
    logic [1:0]          slot;
    slot = 2'($urandom_range(1, 2));
    it = seq_item(dsmpi_pkg::CMD_VERIFY_OFF);
    if (tidy()) it.cell_status_level = 1'b0;
    push_item(it);
    it = seq_item(dsmpi_pkg::CMD_MUX_OFF);
    if (tidy()) it.cell_status_level = 1'b0;
    push_item(it);
    it = seq_item(dsmpi_pkg::CMD_VERIFY_MUX_OFF);
    if (tidy()) begin
      it.mux_enable_level = 1'b0;
      it.switch_enable_n_level = 1'b1;
    end
    push_item(it);
    it = seq_item(dsmpi_pkg::CMD_RAIL_OFF);
    if (tidy()) begin
      it.cell_status_level = 1'b0;
      it.mux_enable_level = 1'b0;
      it.switch_enable_n_level = 1'b1;
    end
    push_item(it);
    it = seq_item(dsmpi_pkg::CMD_SELECT);
    if (tidy()) begin
      it.slot_request = slot;
      it.rail_enable_level = 1'b0;
      it.cell_status_level = 1'b0;
      it.mux_enable_level = 1'b0;
    end
    push_item(it);
    it = seq_item(dsmpi_pkg::CMD_RAIL_ON);
    if (tidy()) begin
      it.rail_enable_level = 1'b0;
      it.cell_status_level = 1'b0;
      it.mux_enable_level = 1'b0;
      it.mux_select_level = (slot == dsmpi_pkg::Slot2);
    end
    push_item(it);
    repeat ($urandom_range(1, 6)) begin
      advance_time(timing_cfg.stable_time_ms / 2 + 1);
      it = seq_item(dsmpi_pkg::CMD_POWER_GOOD);
      if (tidy()) begin
        it.rail_enable_level = 1'b1;
        it.power_good_level = 1'b1;
      end
      push_item(it);
    end
    it = seq_item(dsmpi_pkg::CMD_MUX_ON);
    if (tidy()) begin
      it.rail_enable_level = 1'b1;
      it.power_good_level = 1'b1;
    end
    push_item(it);
    it = seq_item(dsmpi_pkg::CMD_VERIFY_MUX_ON);
    if (tidy()) begin
      it.rail_enable_level = 1'b1;
      it.power_good_level = 1'b1;
      it.mux_enable_level = 1'b1;
      it.switch_enable_n_level = 1'b0;
    end
    push_item(it);
    it = seq_item(dsmpi_pkg::CMD_PWRKEY);
    if (tidy()) begin
      it.rail_enable_level = 1'b1;
      it.power_good_level = 1'b1;
      it.mux_enable_level = 1'b1;
      it.switch_enable_n_level = 1'b0;
    end
    push_item(it);
  endtask

  task automatic queue_fallback();
    dsmpi_pkg::in_item_t it;
    repeat ($urandom_range(1, 5)) begin
      advance_time(timing_cfg.pulse_length_ms / 2 + 1);
      it = seq_item(dsmpi_pkg::CMD_RECOVERY_FALLBACK);
      if (tidy()) begin
        it.cell_status_level = 1'b1;
        it.arg_flag = 1'b1;
      end
      push_item(it);
    end
    it = seq_item(dsmpi_pkg::CMD_RECOVERY_FALLBACK);
    if (tidy()) it.cell_status_level = 1'b0;
    push_item(it);
  endtask

  task automatic queue_random(input int unsigned count);
    int unsigned         stop;
    int unsigned         pick;
    dsmpi_pkg::in_item_t it;
    stop = queued_n + count;
    while (queued_n < stop) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        queue_power_cycle();
      end else if (pick < 65) begin
        queue_fallback();
      end else begin
        advance_time(timing_cfg.stable_time_ms);
        it = random_item(4'($urandom_range(0, CmdUnknownHi)));
        if ($urandom_range(0, 1)) it.time_ms = $urandom;
        push_item(it);
      end
    end
  endtask

  task automatic queue_directed();
    dsmpi_pkg::in_item_t it;
    gen_time = '0;
    it = base_item(dsmpi_pkg::CMD_PWRKEY);
    push_item(it);
    it = base_item(dsmpi_pkg::CMD_PWRKEY);
    it.arg_flag = 1'b1;
    it.time_ms = '1;
    push_item(it);
    it = '1;
    it.command = CmdUnknownHi;
    push_item(it);
    it = base_item(CmdUnknownLo);
    push_item(it);
    it = base_item(dsmpi_pkg::CMD_SELECT);
    it.slot_request = dsmpi_pkg::SlotNone;
    push_item(it);
    it = base_item(dsmpi_pkg::CMD_SELECT);
    it.slot_request = SlotBad;
    push_item(it);
    // switch read-back not wired, then wired but wrong level
    it = base_item(dsmpi_pkg::CMD_VERIFY_MUX_OFF);
    push_item(it);
    it = base_item(dsmpi_pkg::CMD_VERIFY_MUX_OFF);
    it.switch_sense_present = 1'b1;
    push_item(it);
    it = base_item(dsmpi_pkg::CMD_MUX_OFF);
    it.cell_status_level = 1'b1;
    push_item(it);
    it = base_item(dsmpi_pkg::CMD_VERIFY_OFF);
    push_item(it);
    it = base_item(dsmpi_pkg::CMD_MUX_OFF);
    it.write_ok = 1'b0;
    push_item(it);
    it = base_item(dsmpi_pkg::CMD_MUX_OFF);
    push_item(it);
    it = base_item(dsmpi_pkg::CMD_VERIFY_MUX_OFF);
    it.switch_sense_present = 1'b1;
    it.switch_enable_n_level = 1'b1;
    push_item(it);
    it = base_item(dsmpi_pkg::CMD_RAIL_OFF);
    push_item(it);
    it = base_item(dsmpi_pkg::CMD_SELECT);
    it.slot_request = dsmpi_pkg::Slot2;
    push_item(it);
    it = base_item(dsmpi_pkg::CMD_RAIL_ON);
    it.mux_select_level = 1'b1;
    push_item(it);
    // power-good timing across the 32-bit wrap
    it = base_item(dsmpi_pkg::CMD_POWER_GOOD);
    it.rail_enable_level = 1'b1;
    it.power_good_level = 1'b1;
    it.time_ms = 32'hFFFF_FFF0;
    push_item(it);
    it.time_ms = 32'h0000_0010;
    push_item(it);
    it.time_ms = 32'h0000_0060;
    push_item(it);
    it.command = dsmpi_pkg::CMD_MUX_ON;
    push_item(it);
    it.command = dsmpi_pkg::CMD_VERIFY_MUX_ON;
    it.mux_enable_level = 1'b1;
    push_item(it);
    it.switch_sense_present = 1'b1;
    push_item(it);
    it.command = dsmpi_pkg::CMD_PWRKEY;
    it.arg_flag = 1'b1;
    it.switch_sense_present = 1'b0;
    it.switch_enable_n_level = 1'b1;
    push_item(it);
    // fallback pulse across the wrap
    it = base_item(dsmpi_pkg::CMD_RECOVERY_FALLBACK);
    it.cell_status_level = 1'b1;
    push_item(it);
    it.arg_flag = 1'b1;
    it.time_ms = 32'hFFFF_FF00;
    push_item(it);
    it.time_ms = 32'h0000_0100;
    push_item(it);
    it.time_ms = 32'h0000_0600;
    push_item(it);
    it.time_ms = 32'h0000_0700;
    push_item(it);
    it.cell_status_level = 1'b0;
    it.write_ok = 1'b0;
    push_item(it);
    it.write_ok = 1'b1;
    push_item(it);
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_cmds.size() != 0 || in_valid || expected_results.size() != 0);
  endtask

  task automatic write_cfg(input dsmpi_pkg::cfg_reg_e idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == dsmpi_pkg::REG_PULSE_LENGTH) timing_cfg.pulse_length_ms = val;
    else timing_cfg.stable_time_ms = val;
  endtask

  task automatic run_phase(input logic [15:0] pulse_ms, input logic [15:0] stable_ms);
    wait_idle();
    repeat (4) @(posedge clk_i);
    write_cfg(dsmpi_pkg::REG_PULSE_LENGTH, pulse_ms);
    write_cfg(dsmpi_pkg::REG_STABLE_TIME, stable_ms);
    gen_time = $urandom_range(0, 1) ? $urandom : 32'hFFFF_FFFF - $urandom_range(0, 200000);
    queue_random(130);
  endtask

  initial begin
    timing_cfg.pulse_length_ms = dsmpi_pkg::PulseLengthReset;
    timing_cfg.stable_time_ms = dsmpi_pkg::StableTimeReset;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    queue_directed();
    run_phase(16'd0, 16'd0);
    run_phase(16'hFFFF, 16'hFFFF);
    run_phase(16'($urandom_range(1, 300)), 16'($urandom_range(1, 300)));
    run_phase(16'd1, 16'hFFFF);
    run_phase(16'hFFFF, 16'd1);
    run_phase(16'($urandom), 16'($urandom));
    wait_idle();
    repeat (8) @(posedge clk_i);
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #4000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
